/* sv/i2cem_pkg.sv */
// Shared types, codes and reset values for the I2C EEPROM master sequencer.
// No dependencies; the sequencer and step modules import this package.
package i2cem_pkg;

   // Command codes carried by a request transfer
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Configuration register indexes
   localparam logic CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic CSR_RECOVERY_TICKS = 1'b1;

   // Configuration reset values
   localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'h50;
   localparam logic [15:0] RECOVERY_TICKS_RESET = 16'd10000;

   // Which byte of the transaction is on the wire
   localparam logic [1:0] STG_DEVICE = 2'd0;
   localparam logic [1:0] STG_WORD   = 2'd1;
   localparam logic [1:0] STG_DATA   = 2'd2;

   // Pin phases, one-hot
   typedef enum logic [21:0] {
      PH_IDLE     = 22'b1 << 0,
      PH_WB_LO    = 22'b1 << 1,
      PH_WB_SET   = 22'b1 << 2,
      PH_WB_HI    = 22'b1 << 3,
      PH_ACK_LO   = 22'b1 << 4,
      PH_ACK_REL  = 22'b1 << 5,
      PH_ACK_HI   = 22'b1 << 6,
      PH_ACK_WAIT = 22'b1 << 7,
      PH_RS_LO    = 22'b1 << 8,
      PH_RS_REL   = 22'b1 << 9,
      PH_RS_HI    = 22'b1 << 10,
      PH_RS_SDA0  = 22'b1 << 11,
      PH_RB_LO    = 22'b1 << 12,
      PH_RB_HI    = 22'b1 << 13,
      PH_NK_LO    = 22'b1 << 14,
      PH_NK_REL   = 22'b1 << 15,
      PH_NK_HI    = 22'b1 << 16,
      PH_SP_LO    = 22'b1 << 17,
      PH_SP_SDA0  = 22'b1 << 18,
      PH_SP_HI    = 22'b1 << 19,
      PH_SP_REL   = 22'b1 << 20,
      PH_RECOVER  = 22'b1 << 21
   } phase_type;

   // Sequencer state carried from tick to tick
   typedef struct packed {
      phase_type   phase;
      logic [2:0]  bit_index;
      logic [7:0]  tx_shift;
      logic [7:0]  rx_shift;
      logic        is_read;
      logic [7:0]  word_address;
      logic [7:0]  write_data;
      logic [15:0] recovery_count;
      logic        scl;
      logic        sda;
      logic [1:0]  stage;
   } seq_state_type;

   localparam seq_state_type SEQ_RESET = '{
      phase:          PH_IDLE,
      bit_index:      3'd0,
      tx_shift:       8'd0,
      rx_shift:       8'd0,
      is_read:        1'b0,
      word_address:   8'd0,
      write_data:     8'd0,
      recovery_count: 16'd0,
      scl:            1'b1,
      sda:            1'b1,
      stage:          STG_DEVICE
   };

   // One result transfer
   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       read_valid;
      logic [7:0] read_data;
   } rsp_item_type;

   // Configuration values handed to the step logic
   typedef struct packed {
      logic [6:0]  device_address;
      logic [15:0] recovery_ticks;
   } cfg_type;

endpackage

/* sv/i2cem_intf.sv */
// Valid/ready channel interfaces of the I2C EEPROM master sequencer:
// request, result and configuration write. Depends on nothing.
interface i2cem_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] word_address;
   logic [7:0] write_data;
   logic       sda_in;

   modport source (output valid, output opcode, output word_address, output write_data,
                   output sda_in, input ready);
   modport sink   (input valid, input opcode, input word_address, input write_data,
                   input sda_in, output ready);
endinterface

interface i2cem_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic       busy_res;
   logic       read_valid;
   logic [7:0] read_data;

   modport source (output valid, output scl_level, output sda_level, output busy_res,
                   output read_valid, output read_data, input ready);
   modport sink   (input valid, input scl_level, input sda_level, input busy_res,
                   input read_valid, input read_data, output ready);
endinterface

interface i2cem_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [15:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

/* sv/i2c_eeprom_master_sequencer.sv */
// I2C EEPROM master sequencer (byte write and random read), one pin step per
// request transfer, with a two-entry result buffer. Takes one request transfer per clock
// and returns exactly one result transfer for each; the rate is limited only by
// the result channel, and a request is still taken while one result waits in
// the output register, the skid register absorbing it. Depends on i2cem_pkg,
// the channel interfaces and i2cem_step. Configuration writes are taken on
// every clock and must only be issued while the sequencer is idle.
module i2c_eeprom_master_sequencer
   import i2cem_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   i2cem_req_if.sink   req_ch,
   i2cem_rsp_if.source rsp_ch,
   i2cem_csr_if.sink   csr_ch
);

   cfg_type       cfg_ff;
   seq_state_type state_ff;
   seq_state_type state_in;
   rsp_item_type  step_result;
   rsp_item_type  out_ff;
   rsp_item_type  skid_ff;
   logic          out_valid_ff;
   logic          skid_valid_ff;
   logic          push;
   logic          pop;

   // Configuration registers, always ready
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address <= DEVICE_ADDRESS_RESET;
         cfg_ff.recovery_ticks <= RECOVERY_TICKS_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_DEVICE_ADDRESS: cfg_ff.device_address <= csr_ch.wdata[6:0];
            CSR_RECOVERY_TICKS: cfg_ff.recovery_ticks <= csr_ch.wdata;
            default: ;
         endcase
      end
   end

   // Handshake: accept while the skid register is free
   assign req_ch.ready = !skid_valid_ff;
   assign push         = req_ch.valid && req_ch.ready;
   assign pop          = out_valid_ff && rsp_ch.ready;

   i2cem_step u_step (
      .cur          (state_ff),
      .cfg          (cfg_ff),
      .opcode       (req_ch.opcode),
      .word_address (req_ch.word_address),
      .write_data   (req_ch.write_data),
      .sda_in       (req_ch.sda_in),
      .nxt          (state_in),
      .result       (step_result)
   );

   // Advance the sequencer state on each accepted transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_RESET;
      end else if (push) begin
         state_ff <= state_in;
      end
   end

   // Output register plus skid register, order preserved
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         if (out_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (push) begin
            out_ff <= step_result;
         end
      end else if (push) begin
         if (out_valid_ff) begin
            skid_ff <= step_result;
         end else begin
            out_ff <= step_result;
         end
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.scl_level  = out_ff.scl_level;
   assign rsp_ch.sda_level  = out_ff.sda_level;
   assign rsp_ch.busy_res   = out_ff.busy_res;
   assign rsp_ch.read_valid = out_ff.read_valid;
   assign rsp_ch.read_data  = out_ff.read_data;

   // The skid register only holds data behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register valid while output register empty");

   // A stalled result plus a new transfer lands in the skid register
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (push && out_valid_ff && !rsp_ch.ready) |=> skid_valid_ff)
      else $error("result lost on stall");

   // A completed read always leaves the sequencer idle
   a_read_idle: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.read_valid) |-> !out_ff.busy_res)
      else $error("read completion reported while busy");

   // Every accepted transfer produces a result
   a_push_result: assert property (@(posedge clock) disable iff (reset)
      push |=> out_valid_ff)
      else $error("accepted transfer produced no result");

endmodule

/* sv/i2cem_step.sv */
// Next-state and result logic for one tick of the I2C pin sequencer.
// Purely combinational; uses types and codes from i2cem_pkg.
module i2cem_step
   import i2cem_pkg::*;
(
   input  seq_state_type cur,
   input  cfg_type       cfg,
   input  logic [1:0]    opcode,
   input  logic [7:0]    word_address,
   input  logic [7:0]    write_data,
   input  logic          sda_in,
   output seq_state_type nxt,
   output rsp_item_type  result
);

   logic [15:0] recovery_dec;
   logic        read_done;
   logic [7:0]  read_byte;

   assign recovery_dec = (cur.recovery_count != 16'd0) ? cur.recovery_count - 16'd1
                                                       : cur.recovery_count;

   // Advance the pin phase by one tick
   always_comb begin
      nxt       = cur;
      read_done = 1'b0;
      read_byte = 8'd0;
      case (cur.phase)
         PH_IDLE: begin
            if (opcode == OP_WRITE || opcode == OP_READ) begin
               nxt.is_read      = (opcode == OP_READ);
               nxt.word_address = word_address;
               nxt.write_data   = write_data;
               nxt.stage        = STG_DEVICE;
               nxt.sda          = 1'b0;
               nxt.tx_shift     = {cfg.device_address, 1'b0};
               nxt.bit_index    = 3'd0;
               nxt.phase        = PH_WB_LO;
            end
         end
         PH_WB_LO: begin
            nxt.scl   = 1'b0;
            nxt.phase = PH_WB_SET;
         end
         PH_WB_SET: begin
            nxt.sda   = cur.tx_shift[3'd7 - cur.bit_index];
            nxt.phase = PH_WB_HI;
         end
         PH_WB_HI: begin
            nxt.scl = 1'b1;
            if (cur.bit_index == 3'd7) begin
               nxt.bit_index = 3'd0;
               nxt.phase     = PH_ACK_LO;
            end else begin
               nxt.bit_index = cur.bit_index + 3'd1;
               nxt.phase     = PH_WB_LO;
            end
         end
         PH_ACK_LO: begin
            nxt.scl   = 1'b0;
            nxt.phase = PH_ACK_REL;
         end
         PH_ACK_REL: begin
            nxt.sda   = 1'b1;
            nxt.phase = PH_ACK_HI;
         end
         PH_ACK_HI: begin
            nxt.scl   = 1'b1;
            nxt.phase = PH_ACK_WAIT;
         end
         PH_ACK_WAIT: begin
            // hold SCL high until the slave pulls SDA low
            if (!sda_in) begin
               if (cur.stage == STG_DEVICE) begin
                  nxt.stage     = STG_WORD;
                  nxt.tx_shift  = cur.word_address;
                  nxt.bit_index = 3'd0;
                  nxt.phase     = PH_WB_LO;
               end else if (cur.stage == STG_WORD) begin
                  if (cur.is_read) begin
                     nxt.phase = PH_RS_LO;
                  end else begin
                     nxt.stage     = STG_DATA;
                     nxt.tx_shift  = cur.write_data;
                     nxt.bit_index = 3'd0;
                     nxt.phase     = PH_WB_LO;
                  end
               end else if (cur.is_read) begin
                  nxt.rx_shift  = 8'd0;
                  nxt.bit_index = 3'd0;
                  nxt.phase     = PH_RB_LO;
               end else begin
                  nxt.phase = PH_SP_LO;
               end
            end
         end
         PH_RS_LO: begin
            nxt.scl   = 1'b0;
            nxt.phase = PH_RS_REL;
         end
         PH_RS_REL: begin
            nxt.sda   = 1'b1;
            nxt.phase = PH_RS_HI;
         end
         PH_RS_HI: begin
            nxt.scl   = 1'b1;
            nxt.phase = PH_RS_SDA0;
         end
         PH_RS_SDA0: begin
            // repeated start, then the address with the read bit
            nxt.sda       = 1'b0;
            nxt.stage     = STG_DATA;
            nxt.tx_shift  = {cfg.device_address, 1'b1};
            nxt.bit_index = 3'd0;
            nxt.phase     = PH_WB_LO;
         end
         PH_RB_LO: begin
            nxt.scl   = 1'b0;
            nxt.phase = PH_RB_HI;
         end
         PH_RB_HI: begin
            nxt.scl      = 1'b1;
            nxt.rx_shift = {cur.rx_shift[6:0], sda_in};
            if (cur.bit_index == 3'd7) begin
               nxt.bit_index = 3'd0;
               nxt.phase     = PH_NK_LO;
            end else begin
               nxt.bit_index = cur.bit_index + 3'd1;
               nxt.phase     = PH_RB_LO;
            end
         end
         PH_NK_LO: begin
            nxt.scl   = 1'b0;
            nxt.phase = PH_NK_REL;
         end
         PH_NK_REL: begin
            nxt.sda   = 1'b1;
            nxt.phase = PH_NK_HI;
         end
         PH_NK_HI: begin
            nxt.scl   = 1'b1;
            nxt.phase = PH_SP_LO;
         end
         PH_SP_LO: begin
            nxt.scl   = 1'b0;
            nxt.phase = PH_SP_SDA0;
         end
         PH_SP_SDA0: begin
            nxt.sda   = 1'b0;
            nxt.phase = PH_SP_HI;
         end
         PH_SP_HI: begin
            nxt.scl   = 1'b1;
            nxt.phase = PH_SP_REL;
         end
         PH_SP_REL: begin
            nxt.sda = 1'b1;
            if (cur.is_read) begin
               read_done = 1'b1;
               read_byte = cur.rx_shift;
               nxt.phase = PH_IDLE;
            end else if (cfg.recovery_ticks == 16'd0) begin
               nxt.phase = PH_IDLE;
            end else begin
               nxt.recovery_count = cfg.recovery_ticks;
               nxt.phase          = PH_RECOVER;
            end
         end
         PH_RECOVER: begin
            nxt.recovery_count = recovery_dec;
            if (recovery_dec == 16'd0) begin
               nxt.phase = PH_IDLE;
            end
         end
         default: begin
            nxt.phase = PH_IDLE;
         end
      endcase
   end

   // Pin levels and status after this tick
   assign result.scl_level  = nxt.scl;
   assign result.sda_level  = nxt.sda;
   assign result.busy_res   = (nxt.phase != PH_IDLE);
   assign result.read_valid = read_done;
   assign result.read_data  = read_byte;

endmodule
